/* src/rlir_pkg.sv */
// ----------------------------------------------------------------------------
// rlir_pkg
// Shared sizes, node types and sequencer states for the longest increasing
// run segment tree.
// ----------------------------------------------------------------------------
package rlir_pkg;

  localparam int ELEMENTS = 1024;
  localparam int IDX_W    = $clog2(ELEMENTS);
  localparam int NODE_W   = IDX_W + 1;
  localparam int CNT_W    = IDX_W + 1;
  localparam int LVL_W    = $clog2(IDX_W + 2);
  localparam int VAL_W    = 32;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    count_t best;
    count_t lrun;
    count_t rrun;
  } node_t;

  typedef struct packed {
    logic   valid;
    count_t len;
    node_t  cnt;
  } span_t;

  localparam node_t NODE_ONE = '{best: count_t'(1), lrun: count_t'(1), rrun: count_t'(1)};

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_W_FETCH,
    S_W_JOIN,
    S_Q_STEP,
    S_Q_LFETCH,
    S_Q_LJOIN,
    S_Q_RFETCH,
    S_Q_RJOIN,
    S_Q_FFETCH,
    S_Q_FJOIN,
    S_Q_DONE
  } state_t;

endpackage

/* src/range_longest_increasing_run.sv */
// ----------------------------------------------------------------------------
// range_longest_increasing_run
// Segment tree over a signed value array; answers the longest strictly
// increasing contiguous run in an index range and updates single elements.
// ----------------------------------------------------------------------------
//  channel | signals                                       | transaction
//  --------+-----------------------------------------------+--------------------
//  request | req_valid req_ready kind first_index          | write or query
//          | last_index new_value                          |
//  response| rsp_valid rsp_ready longest_run               | one per query
//
//  Write: one shared join unit; each of the 10 tree levels does a node and
//  element memory read, then a join and node write. Query: per level walked, a
//  step with a left and a right fetch and join where needed, then a final fetch
//  and join; an empty range goes straight to the response. After reset a
//  clearing pass fills both memories; req_ready stays low meanwhile. A finished
//  query waits in the sequencer while the previous response is still held.
// ----------------------------------------------------------------------------
module range_longest_increasing_run (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic                              kind,
  input  logic [rlir_pkg::IDX_W-1:0]        first_index,
  input  logic [rlir_pkg::IDX_W-1:0]        last_index,
  input  logic signed [rlir_pkg::VAL_W-1:0] new_value,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [rlir_pkg::CNT_W-1:0]        longest_run
);

  localparam int IW = rlir_pkg::IDX_W;
  localparam int NW = rlir_pkg::NODE_W;
  localparam int DEPTH_N = 2 * rlir_pkg::ELEMENTS;

  rlir_pkg::state_t state, state_next;

  logic [NW-1:0]               clr, clr_next;
  logic [IW-1:0]               idx, idx_next;
  logic [NW-1:0]               p, p_next;
  logic [rlir_pkg::LVL_W-1:0]  lvl, lvl_next;
  rlir_pkg::node_t             cur, cur_next;
  logic [NW:0]                 l, l_next;
  logic [NW:0]                 r, r_next;
  rlir_pkg::span_t             acc_l, acc_l_next;
  rlir_pkg::span_t             acc_r, acc_r_next;
  logic [IW:0]                 lnext, lnext_next;
  logic [IW:0]                 rlo, rlo_next;
  rlir_pkg::count_t            result, result_next;
  logic                        rsp_valid_next;
  rlir_pkg::count_t            longest_run_next;

  // memories
  logic signed [rlir_pkg::VAL_W-1:0] elem_mem [rlir_pkg::ELEMENTS];
  rlir_pkg::node_t                   node_mem [DEPTH_N];

  logic                              elem_we;
  logic [IW-1:0]                     elem_waddr;
  logic signed [rlir_pkg::VAL_W-1:0] elem_wdata;
  logic [IW-1:0]                     elem_a_addr, elem_b_addr;
  logic signed [rlir_pkg::VAL_W-1:0] elem_a_q, elem_b_q;

  logic                              node_we;
  logic [NW-1:0]                     node_waddr;
  rlir_pkg::node_t                   node_wdata;
  logic [NW-1:0]                     node_raddr;
  rlir_pkg::node_t                   node_q;

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    elem_a_q <= elem_mem[elem_a_addr];
    elem_b_q <= elem_mem[elem_b_addr];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  // shared join unit
  rlir_pkg::span_t  ja, jb, jr;
  rlir_pkg::count_t clen;
  logic             inc;
  rlir_pkg::count_t j_best0, j_lr, j_rr, j_mid, j_m1, j_m2;

  assign clen = rlir_pkg::count_t'(1) << lvl;

  always_comb begin
    ja = '0;
    jb = '0;
    case (state)
      rlir_pkg::S_W_JOIN: begin
        if (p[0]) begin
          ja = '{valid: 1'b1, len: clen, cnt: node_q};
          jb = '{valid: 1'b1, len: clen, cnt: cur};
        end else begin
          ja = '{valid: 1'b1, len: clen, cnt: cur};
          jb = '{valid: 1'b1, len: clen, cnt: node_q};
        end
      end
      rlir_pkg::S_Q_LJOIN: begin
        ja = acc_l;
        jb = '{valid: 1'b1, len: clen, cnt: node_q};
      end
      rlir_pkg::S_Q_RJOIN: begin
        ja = '{valid: 1'b1, len: clen, cnt: node_q};
        jb = acc_r;
      end
      rlir_pkg::S_Q_FJOIN: begin
        ja = acc_l;
        jb = acc_r;
      end
      default: begin
        ja = '0;
        jb = '0;
      end
    endcase
  end

  always_comb begin
    inc     = elem_a_q < elem_b_q;
    j_best0 = (ja.cnt.best > jb.cnt.best) ? ja.cnt.best : jb.cnt.best;
    j_lr    = (inc && ja.cnt.best == ja.len) ? ja.cnt.lrun + jb.cnt.lrun : ja.cnt.lrun;
    j_rr    = (inc && jb.cnt.best == jb.len) ? jb.cnt.rrun + ja.cnt.rrun : jb.cnt.rrun;
    j_mid   = ja.cnt.rrun + jb.cnt.lrun;
    j_m1    = (j_best0 > j_mid) ? j_best0 : j_mid;
    j_m2    = (j_lr > j_rr) ? j_lr : j_rr;
    if (!ja.valid) begin
      jr = jb;
    end else if (!jb.valid) begin
      jr = ja;
    end else begin
      jr.valid    = 1'b1;
      jr.len      = ja.len + jb.len;
      jr.cnt.lrun = j_lr;
      jr.cnt.rrun = j_rr;
      jr.cnt.best = inc ? ((j_m1 > j_m2) ? j_m1 : j_m2) : j_best0;
    end
  end

  // boundary elements of the write path parent
  logic [IW-1:0] lmask, hmask, w_mid, w_mid1;
  logic [NW-1:0] parent;
  logic [NW:0]   l_inc, r_dec;
  logic [IW:0]   lnext_m1, rlo_m1;

  assign lmask    = IW'(clen - rlir_pkg::count_t'(1));
  assign hmask    = {lmask[IW-2:0], 1'b1};
  assign w_mid    = (idx & ~hmask) | lmask;
  assign w_mid1   = (idx & ~hmask) | clen[IW-1:0];
  assign parent   = {1'b0, p[NW-1:1]};
  assign l_inc    = l + (NW+1)'(1);
  assign r_dec    = r - (NW+1)'(1);
  assign lnext_m1 = lnext - (IW+1)'(1);
  assign rlo_m1   = rlo - (IW+1)'(1);

  assign req_ready = (state == rlir_pkg::S_IDLE);

  always_comb begin
    state_next       = state;
    clr_next         = clr;
    idx_next         = idx;
    p_next           = p;
    lvl_next         = lvl;
    cur_next         = cur;
    l_next           = l;
    r_next           = r;
    acc_l_next       = acc_l;
    acc_r_next       = acc_r;
    lnext_next       = lnext;
    rlo_next         = rlo;
    result_next      = result;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    longest_run_next = longest_run;

    elem_we     = 1'b0;
    elem_waddr  = idx;
    elem_wdata  = new_value;
    elem_a_addr = lnext_m1[IW-1:0];
    elem_b_addr = lnext[IW-1:0];
    node_we     = 1'b0;
    node_waddr  = parent;
    node_wdata  = jr.cnt;
    node_raddr  = l[NW-1:0];

    case (state)
      rlir_pkg::S_CLEAR: begin
        elem_we    = 1'b1;
        elem_waddr = clr[IW-1:0];
        elem_wdata = '0;
        node_we    = 1'b1;
        node_waddr = clr;
        node_wdata = rlir_pkg::NODE_ONE;
        clr_next   = clr + NW'(1);
        if (&clr) begin
          state_next = rlir_pkg::S_IDLE;
        end
      end
      rlir_pkg::S_IDLE: begin
        if (req_valid) begin
          if (kind == rlir_pkg::KIND_WRITE) begin
            elem_we    = 1'b1;
            elem_waddr = first_index;
            elem_wdata = new_value;
            idx_next   = first_index;
            p_next     = NW'(rlir_pkg::ELEMENTS) + NW'(first_index);
            cur_next   = rlir_pkg::NODE_ONE;
            lvl_next   = '0;
            state_next = rlir_pkg::S_W_FETCH;
          end else if (first_index > last_index) begin
            result_next = '0;
            state_next  = rlir_pkg::S_Q_DONE;
          end else begin
            l_next     = (NW+1)'(rlir_pkg::ELEMENTS) + (NW+1)'(first_index);
            r_next     = (NW+1)'(rlir_pkg::ELEMENTS) + (NW+1)'(last_index) + (NW+1)'(1);
            lnext_next = {1'b0, first_index};
            rlo_next   = {1'b0, last_index} + (IW+1)'(1);
            acc_l_next = '0;
            acc_r_next = '0;
            lvl_next   = '0;
            state_next = rlir_pkg::S_Q_STEP;
          end
        end
      end
      rlir_pkg::S_W_FETCH: begin
        node_raddr  = p ^ NW'(1);
        elem_a_addr = w_mid;
        elem_b_addr = w_mid1;
        state_next  = rlir_pkg::S_W_JOIN;
      end
      rlir_pkg::S_W_JOIN: begin
        node_we    = 1'b1;
        node_waddr = parent;
        node_wdata = jr.cnt;
        cur_next   = jr.cnt;
        p_next     = parent;
        lvl_next   = lvl + rlir_pkg::LVL_W'(1);
        state_next = (parent == NW'(1)) ? rlir_pkg::S_IDLE : rlir_pkg::S_W_FETCH;
      end
      rlir_pkg::S_Q_STEP: begin
        if (l < r) begin
          if (l[0]) begin
            state_next = rlir_pkg::S_Q_LFETCH;
          end else if (r[0]) begin
            state_next = rlir_pkg::S_Q_RFETCH;
          end else begin
            l_next   = l >> 1;
            r_next   = r >> 1;
            lvl_next = lvl + rlir_pkg::LVL_W'(1);
          end
        end else begin
          state_next = rlir_pkg::S_Q_FFETCH;
        end
      end
      rlir_pkg::S_Q_LFETCH: begin
        node_raddr  = l[NW-1:0];
        elem_a_addr = lnext_m1[IW-1:0];
        elem_b_addr = lnext[IW-1:0];
        state_next  = rlir_pkg::S_Q_LJOIN;
      end
      rlir_pkg::S_Q_LJOIN: begin
        acc_l_next = jr;
        lnext_next = lnext + clen;
        if (r[0]) begin
          l_next     = l_inc;
          state_next = rlir_pkg::S_Q_RFETCH;
        end else begin
          l_next     = l_inc >> 1;
          r_next     = r >> 1;
          lvl_next   = lvl + rlir_pkg::LVL_W'(1);
          state_next = rlir_pkg::S_Q_STEP;
        end
      end
      rlir_pkg::S_Q_RFETCH: begin
        node_raddr  = r_dec[NW-1:0];
        elem_a_addr = rlo_m1[IW-1:0];
        elem_b_addr = rlo[IW-1:0];
        state_next  = rlir_pkg::S_Q_RJOIN;
      end
      rlir_pkg::S_Q_RJOIN: begin
        acc_r_next = jr;
        rlo_next   = rlo - clen;
        l_next     = l >> 1;
        r_next     = r_dec >> 1;
        lvl_next   = lvl + rlir_pkg::LVL_W'(1);
        state_next = rlir_pkg::S_Q_STEP;
      end
      rlir_pkg::S_Q_FFETCH: begin
        elem_a_addr = lnext_m1[IW-1:0];
        elem_b_addr = lnext[IW-1:0];
        state_next  = rlir_pkg::S_Q_FJOIN;
      end
      rlir_pkg::S_Q_FJOIN: begin
        result_next = jr.valid ? jr.cnt.best : '0;
        state_next  = rlir_pkg::S_Q_DONE;
      end
      rlir_pkg::S_Q_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next   = 1'b1;
          longest_run_next = result;
          state_next       = rlir_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rlir_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rlir_pkg::S_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    p           <= p_next;
    lvl         <= lvl_next;
    cur         <= cur_next;
    l           <= l_next;
    r           <= r_next;
    acc_l       <= acc_l_next;
    acc_r       <= acc_r_next;
    lnext       <= lnext_next;
    rlo         <= rlo_next;
    result      <= result_next;
    longest_run <= longest_run_next;
  end

  // checks
  a_run_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> longest_run <= rlir_pkg::count_t'(rlir_pkg::ELEMENTS))
    else $error("response run longer than the array");

  a_join_sane: assert property (@(posedge clk) disable iff (rst)
    (state == rlir_pkg::S_W_JOIN || state == rlir_pkg::S_Q_LJOIN ||
     state == rlir_pkg::S_Q_RJOIN || state == rlir_pkg::S_Q_FJOIN) && jr.valid
    |-> jr.cnt.best <= jr.len && jr.cnt.lrun <= jr.cnt.best && jr.cnt.rrun <= jr.cnt.best)
    else $error("joined counts inconsistent");

  a_walk_node: assert property (@(posedge clk) disable iff (rst)
    state == rlir_pkg::S_W_FETCH |-> p[NW-1:1] != '0)
    else $error("update walk past the root");

  a_meet: assert property (@(posedge clk) disable iff (rst)
    state == rlir_pkg::S_Q_FFETCH && acc_l.valid && acc_r.valid |-> lnext == rlo)
    else $error("left and right partial spans do not meet");

endmodule
